// ===== rtl/lpwe_pkg.sv =====
`default_nettype none

package lpwe_pkg;

	// channel and register widths
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int POS_W     = 4;

	// pattern bytes sent for one 2-bit pair
	localparam logic [CHAN_W-1:0] PAT_00 = 8'h88;
	localparam logic [CHAN_W-1:0] PAT_01 = 8'h8e;
	localparam logic [CHAN_W-1:0] PAT_10 = 8'he8;
	localparam logic [CHAN_W-1:0] PAT_11 = 8'hee;

	// last pattern byte position of a pixel, counting down to zero
	localparam logic [POS_W-1:0] LAST_POS_RGB  = 4'd11;
	localparam logic [POS_W-1:0] LAST_POS_RGBW = 4'd15;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_COLOR_ORDER = 2'd1,
		REG_RGBW_MODE = 2'd2
	} reg_index_t;

	// wire order codes
	typedef enum logic [2:0] {
		WIRE_GRB = 3'd0,
		WIRE_RGB = 3'd1,
		WIRE_BRG = 3'd2,
		WIRE_RBG = 3'd3,
		WIRE_GBR = 3'd4,
		WIRE_BGR = 3'd5
	} color_order_t;

	// floor(value * bright / 255), exact for all 8-bit operands
	function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] value,
		input logic [CHAN_W-1:0] bright);
		logic [2*CHAN_W-1:0] prod;
		logic [2*CHAN_W:0] sum;
		prod = value * bright;
		sum = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]} +
			{{(2*CHAN_W){1'b0}}, 1'b1};
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

	// pattern byte for one pair of data bits
	function automatic logic [CHAN_W-1:0] pair_pattern(input logic [1:0] pair);
		logic [CHAN_W-1:0] pat;
		case (pair)
			2'b00: pat = PAT_00;
			2'b01: pat = PAT_01;
			2'b10: pat = PAT_10;
			default: pat = PAT_11;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lpwe_if.sv =====
`default_nettype none

// pixel request channel
interface lpwe_pixel_if;
	logic valid;
	logic ready;
	logic [lpwe_pkg::CHAN_W-1:0] red;
	logic [lpwe_pkg::CHAN_W-1:0] green;
	logic [lpwe_pkg::CHAN_W-1:0] blue;
	logic [lpwe_pkg::CHAN_W-1:0] white;
	logic last_pixel;

	modport source (output valid, red, green, blue, white, last_pixel, input ready);
	modport sink (input valid, red, green, blue, white, last_pixel, output ready);
endinterface

// pattern byte request channel
interface lpwe_byte_if;
	logic valid;
	logic ready;
	logic [lpwe_pkg::CHAN_W-1:0] wire_byte;
	logic last_of_pixel;
	logic last_of_frame;

	modport source (output valid, wire_byte, last_of_pixel, last_of_frame, input ready);
	modport sink (input valid, wire_byte, last_of_pixel, last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/led_pixel_wire_encoder_unit.sv =====
`default_nettype none

// channel   direction  request contents
// pixel     in         red, green, blue, white, last_pixel
// stream    out        wire_byte, last_of_pixel, last_of_frame
// write_*   in         brightness / color_order / rgbw_mode register writes
//
// a pixel gives 12 pattern bytes (16 in rgbw mode), one per cycle when stream
// is ready.
// the next pixel waits in the input register and is scaled and loaded as the
// last byte of the current one leaves, so pixels follow without a gap.
// a stall on stream holds the output register and the serializer in place.
// arst_n clears all valid state and sets the registers to their reset values.

module led_pixel_wire_encoder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	lpwe_pixel_if.sink pixel,
	lpwe_byte_if.source stream,
	input  wire logic write_en,
	input  wire logic [lpwe_pkg::CFG_IDX_W-1:0] write_index,
	input  wire logic [lpwe_pkg::CFG_DATA_W-1:0] write_data
);

	localparam int W = lpwe_pkg::CHAN_W;

	// configuration registers
	logic [W-1:0] brightness_q;
	lpwe_pkg::color_order_t color_order_q;
	logic [2:0] order_raw_q;
	logic rgbw_mode_q;

	// input stage
	logic valid_s1;
	logic [W-1:0] red_s1, green_s1, blue_s1, white_s1;
	logic last_s1;

	// serializer
	logic busy_q;
	logic [4*W-1:0] held_q;
	logic [lpwe_pkg::POS_W-1:0] pos_q;
	logic frame_q;

	// output register
	logic out_valid_q;
	logic [W-1:0] out_byte_q;
	logic out_lop_q;
	logic out_lof_q;

	logic out_adv, emit, emit_last, load_held;
	logic [W-1:0] r_sc, g_sc, b_sc, w_sc;
	logic [W-1:0] c0, c1, c2;

	assign color_order_q = lpwe_pkg::color_order_t'(order_raw_q);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= {W{1'b1}};
			order_raw_q <= lpwe_pkg::WIRE_GRB;
			rgbw_mode_q <= 1'b0;
		end else if (write_en) begin
			unique case (write_index)
				lpwe_pkg::REG_BRIGHTNESS: brightness_q <= write_data[W-1:0];
				lpwe_pkg::REG_COLOR_ORDER: order_raw_q <= write_data[2:0];
				lpwe_pkg::REG_RGBW_MODE: rgbw_mode_q <= write_data[0];
				default: ;
			endcase
		end
	end

	// handshake control
	assign out_adv = !out_valid_q || stream.ready;
	assign emit = busy_q && out_adv;
	assign emit_last = emit && (pos_q == '0);
	assign load_held = valid_s1 && (!busy_q || emit_last);
	assign pixel.ready = !valid_s1 || load_held;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			red_s1 <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1 <= pixel.blue;
			white_s1 <= pixel.white;
			last_s1 <= pixel.last_pixel;
		end
	end

	// brightness scaling
	assign r_sc = lpwe_pkg::scale8(red_s1, brightness_q);
	assign g_sc = lpwe_pkg::scale8(green_s1, brightness_q);
	assign b_sc = lpwe_pkg::scale8(blue_s1, brightness_q);
	assign w_sc = lpwe_pkg::scale8(white_s1, brightness_q);

	// wire order, unused codes fall back to grb
	always_comb begin
		unique case (color_order_q)
			lpwe_pkg::WIRE_RGB: begin c0 = r_sc; c1 = g_sc; c2 = b_sc; end
			lpwe_pkg::WIRE_BRG: begin c0 = b_sc; c1 = r_sc; c2 = g_sc; end
			lpwe_pkg::WIRE_RBG: begin c0 = r_sc; c1 = b_sc; c2 = g_sc; end
			lpwe_pkg::WIRE_GBR: begin c0 = g_sc; c1 = b_sc; c2 = r_sc; end
			lpwe_pkg::WIRE_BGR: begin c0 = b_sc; c1 = g_sc; c2 = r_sc; end
			default: begin c0 = g_sc; c1 = r_sc; c2 = b_sc; end
		endcase
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load_held) begin
			busy_q <= 1'b1;
		end else if (emit_last) begin
			busy_q <= 1'b0;
		end
	end

	// held pixel shifts out two bits per pattern byte
	always_ff @(posedge clk) begin
		if (load_held) begin
			held_q <= {c0, c1, c2, rgbw_mode_q ? w_sc : {W{1'b0}}};
			pos_q <= rgbw_mode_q ? lpwe_pkg::LAST_POS_RGBW : lpwe_pkg::LAST_POS_RGB;
			frame_q <= last_s1;
		end else if (emit) begin
			held_q <= {held_q[4*W-3:0], 2'b00};
			pos_q <= pos_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= lpwe_pkg::pair_pattern(held_q[4*W-1:4*W-2]);
			out_lop_q <= (pos_q == '0);
			out_lof_q <= (pos_q == '0) && frame_q;
		end
	end

	assign stream.valid = out_valid_q;
	assign stream.wire_byte = out_byte_q;
	assign stream.last_of_pixel = out_lop_q;
	assign stream.last_of_frame = out_lof_q;

`ifndef SYNTH
	// frame end only ever rides on a pixel end
	a_frame_on_pixel_end: assert property (@(posedge clk) disable iff (!arst_n)
		stream.valid |-> (!stream.last_of_frame || stream.last_of_pixel))
		else $error("last_of_frame without last_of_pixel");

	// the final byte of a pixel shows up marked in the next cycle
	a_last_byte_marked: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (stream.valid && stream.last_of_pixel))
		else $error("last byte of pixel not marked");

	// a held pixel is never overwritten mid-serialization
	a_no_early_load: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !emit_last) |-> !load_held)
		else $error("held pixel replaced before its last byte");
`endif

endmodule

`default_nettype wire

// ===== test/led_pixel_wire_encoder_unit_checker.sv =====
`timescale 1ns / 100ps

module led_pixel_wire_encoder_unit_checker
	import lpwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lpwe_pixel_if pixel,
	lpwe_byte_if stream,
	input  logic write_en,
	input  logic [CFG_IDX_W-1:0] write_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	output int fail_count,
	output int checked_bytes,
	output int pending_bytes
);

	typedef struct packed {
		logic [CHAN_W-1:0] wire_byte;
		logic last_of_pixel;
		logic last_of_frame;
	} pattern_byte_t;

	// shadow copy of the register file
	logic [CHAN_W-1:0] bright_level;
	logic [2:0] wire_order;
	logic white_enabled;

	pattern_byte_t expected_bytes[$];

	// floor(level * brightness / 255)
	function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] level);
		int unsigned product;
		product = level * bright_level;
		return CHAN_W'(product / 255);
	endfunction

	// expand one accepted pixel into its pattern bytes
	task automatic encode_pixel();
		logic [CHAN_W-1:0] r, g, b, w, c0, c1, c2;
		logic [31:0] word;
		logic [1:0] pair;
		int count;
		pattern_byte_t item;
		r = dim(pixel.red);
		g = dim(pixel.green);
		b = dim(pixel.blue);
		w = dim(pixel.white);
		case (wire_order)
			WIRE_RGB: begin
				c0 = r; c1 = g; c2 = b;
			end
			WIRE_BRG: begin
				c0 = b; c1 = r; c2 = g;
			end
			WIRE_RBG: begin
				c0 = r; c1 = b; c2 = g;
			end
			WIRE_GBR: begin
				c0 = g; c1 = b; c2 = r;
			end
			WIRE_BGR: begin
				c0 = b; c1 = g; c2 = r;
			end
			// spare codes fall back to grb
			default: begin
				c0 = g; c1 = r; c2 = b;
			end
		endcase
		word = {c0, c1, c2, white_enabled ? w : 8'h00};
		count = white_enabled ? 16 : 12;
		for (int k = 0; k < count; k++) begin
			pair = word[31 - 2*k -: 2];
			case (pair)
				2'b00: item.wire_byte = PAT_00;
				2'b01: item.wire_byte = PAT_01;
				2'b10: item.wire_byte = PAT_10;
				default: item.wire_byte = PAT_11;
			endcase
			item.last_of_pixel = (k == count - 1);
			item.last_of_frame = (k == count - 1) && pixel.last_pixel;
			expected_bytes.push_back(item);
		end
	endtask

	// compare one accepted byte request with the oldest expectation
	task automatic take_byte();
		pattern_byte_t got, want;
		got = {stream.wire_byte, stream.last_of_pixel, stream.last_of_frame};
		checked_bytes++;
		if (expected_bytes.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: byte %h (pixel end %b, frame end %b) with nothing outstanding",
					$time, got.wire_byte, got.last_of_pixel, got.last_of_frame);
		end else begin
			want = expected_bytes.pop_front();
			if (got.wire_byte !== want.wire_byte ||
				got.last_of_pixel !== want.last_of_pixel ||
				got.last_of_frame !== want.last_of_frame) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: byte mismatch: expected %h/%b/%b, got %h/%b/%b",
						$time, want.wire_byte, want.last_of_pixel, want.last_of_frame,
						got.wire_byte, got.last_of_pixel, got.last_of_frame);
			end
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_level = 8'hff;
			wire_order = WIRE_GRB;
			white_enabled = 1'b0;
			expected_bytes.delete();
			pending_bytes <= 0;
		end else begin
			if (stream.valid && stream.ready)
				take_byte();
			if (write_en) begin
				case (write_index)
					REG_BRIGHTNESS: bright_level = write_data;
					REG_COLOR_ORDER: wire_order = write_data[2:0];
					REG_RGBW_MODE: white_enabled = write_data[0];
					default: ;
				endcase
			end
			if (pixel.valid && pixel.ready)
				encode_pixel();
			pending_bytes <= expected_bytes.size();
		end
	end

endmodule

// ===== test/led_pixel_wire_encoder_unit_tb.sv =====
`timescale 1ns / 100ps

module led_pixel_wire_encoder_unit_tb;
	import lpwe_pkg::*;

	localparam int unsigned TIMEOUT_NS = 2_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [2:0] ORDER_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic write_en;
	logic [CFG_IDX_W-1:0] write_index;
	logic [CFG_DATA_W-1:0] write_data;
	logic calm = 1'b0;

	int fail_count;
	int checked_bytes;
	int pending_bytes;
	int pixels_sent = 0;
	int frame_ends = 0;

	lpwe_pixel_if pixel_ch();
	lpwe_byte_if byte_ch();

	led_pixel_wire_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.stream(byte_ch),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data)
	);

	led_pixel_wire_encoder_unit_checker byte_check (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.stream(byte_ch),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data),
		.fail_count(fail_count),
		.checked_bytes(checked_bytes),
		.pending_bytes(pending_bytes)
	);

	always #2 clk = ~clk;

	// give up if the run hangs
	initial begin
		#(TIMEOUT_NS);
		$display("led_pixel_wire_encoder_unit test failed");
		$finish;
	end

	// random stall bursts and quiet stretches on the byte stream
	initial begin : stream_stall
		int stall_left;
		int quiet_left;
		stall_left = 0;
		quiet_left = 0;
		byte_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (quiet_left > 0)
				quiet_left--;
			else if (!calm) begin
				case ($urandom_range(0, 7))
					0, 1: stall_left = $urandom_range(1, 13);
					2: quiet_left = $urandom_range(20, 60);
					default: ;
				endcase
			end
			byte_ch.ready <= (stall_left == 0);
		end
	end

	// mostly random, with the extremes now and then
	function automatic logic [7:0] pick_byte(input int odds);
		int roll;
		roll = $urandom_range(0, odds - 1);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hff;
		return 8'($urandom);
	endfunction

	task automatic reg_write(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
		write_en <= 1'b1;
		write_index <= index;
		write_data <= value;
		@(posedge clk);
	endtask

	// hold off pixels until every pattern byte has come out
	task automatic wait_drained();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes != 0);
	endtask

	task automatic set_config(input logic [7:0] bright, input logic [7:0] order,
		input logic [7:0] rgbw);
		wait_drained();
		reg_write(REG_BRIGHTNESS, bright);
		reg_write(REG_COLOR_ORDER, order);
		reg_write(REG_RGBW_MODE, rgbw);
		write_en <= 1'b0;
	endtask

	// one pixel request, with a random gap ahead of it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] w, input logic last);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 13);
		if (gap != 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.red <= r;
		pixel_ch.green <= g;
		pixel_ch.blue <= b;
		pixel_ch.white <= w;
		pixel_ch.last_pixel <= last;
		do @(posedge clk); while (!pixel_ch.ready);
		pixels_sent++;
		if (last)
			frame_ends++;
	endtask

	initial begin
		arst_n = 1'b0;
		write_en = 1'b0;
		write_index = '0;
		write_data = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.red = '0;
		pixel_ch.green = '0;
		pixel_ch.blue = '0;
		pixel_ch.white = '0;
		pixel_ch.last_pixel = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: grb, three channels, full brightness
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
		// white must be dropped without rgbw mode
		send_pixel(8'hff, 8'h00, 8'h00, 8'hff, 1'b0);
		send_pixel(8'h55, 8'haa, 8'h3c, 8'hc3, 1'b1);

		// four channels
		set_config(8'hff, 8'(WIRE_RGB), 8'h01);
		send_pixel(8'h12, 8'h34, 8'h56, 8'hff, 1'b0);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
		send_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);

		// zero brightness sends only the low pattern
		set_config(8'h00, 8'(WIRE_BGR), 8'h01);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
		set_config(8'h01, 8'(WIRE_GBR), 8'h01);
		send_pixel(8'hff, 8'hfe, 8'h01, 8'h80, 1'b0);
		set_config(8'h80, 8'(WIRE_RBG), 8'h00);
		send_pixel(8'hff, 8'h80, 8'h7f, 8'h01, 1'b1);

		// remaining order codes, spare ones included
		for (int code = WIRE_BRG; code <= ORDER_SPARE_7; code++) begin
			set_config(8'hff, 8'(code), 8'h00);
			send_pixel(pick_byte(8), pick_byte(8), pick_byte(8), pick_byte(8), code[0]);
		end

		// upper data bits are dropped, spare index is ignored
		wait_drained();
		reg_write(REG_BRIGHTNESS, 8'hc8);
		reg_write(REG_COLOR_ORDER, 8'hf9);
		reg_write(REG_RGBW_MODE, 8'hfe);
		reg_write(REG_SPARE, 8'h00);
		write_en <= 1'b0;
		send_pixel(8'hff, 8'h80, 8'h01, 8'hff, 1'b0);
		send_pixel(8'h9a, 8'h65, 8'hf0, 8'h0f, 1'b1);

		// random phases, each under its own settings; the last one runs without idling
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7)
				calm <= 1'b1;
			set_config(pick_byte(4), {5'($urandom), 3'($urandom)},
				{7'($urandom), 1'($urandom)});
			for (int n = 0; n < 38; n++) begin
				if (phase == 2 && n == 19)
					wait_drained();
				send_pixel(pick_byte(8), pick_byte(8), pick_byte(8), pick_byte(8),
					$urandom_range(0, 7) == 0);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);

		$display("encoded %0d pixels (%0d frame ends) into %0d checked pattern bytes",
			pixels_sent, frame_ends, checked_bytes);
		$display("covered all order codes, rgb and rgbw modes, brightness extremes, stalls");
		if (fail_count == 0 && pending_bytes == 0)
			$display("led_pixel_wire_encoder_unit test passed");
		else
			$display("led_pixel_wire_encoder_unit test failed");
		$finish;
	end

endmodule
